// ===== rtl/tkr_pkg.sv =====
// shared constants, types and control structs for the timed keyframe release block
`default_nettype none

package tkr_pkg;

  // default table depth and per-tick release limit
  localparam int unsigned TKR_MAX_FRAMES  = 64;
  localparam int unsigned TKR_MAX_RESULTS = 64;
  localparam int unsigned TKR_RES_W       = $clog2(TKR_MAX_RESULTS);
  localparam int unsigned TKR_DATA_W      = 32;

  // item operation codes
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_CHECK,
    ST_EMIT
  } state_e;

  // table read address selection
  typedef enum logic [1:0] {
    RD_POS,
    RD_NEXT,
    RD_INS
  } rd_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    k_dec;
    logic    ins_done;
    logic    set_first;
    logic    pos_inc;
    logic    n_inc;
    logic    emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic at_last;
    logic first;
    logic k_zero;
    logic ins_gt;
    logic due;
    logic more;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/timed_keyframe_release.sv =====
// top level of the timed keyframe release block
// Usage:
//   An item is taken when start is high and busy is low. operation_i selects
//   add (insert frame_time_i / frame_payload_i in time order, ties after equal
//   times) or tick (release frames that have come due against elapsed_ms_i).
//   Each released frame appears on the target ports for one cycle with
//   valid_o high; last_of_run_o marks the final frame of a tick and
//   finished_o marks the table's last entry. The receiver cannot stall.
// Sequencing:
//   add walks down from the end of the table, reading each entry in
//   ST_INS_RD and moving it up one place in ST_INS_CMP, until the frame
//   lands; the walk is bound by the single table read port. An add to a
//   full table, or a tick on an empty table or on its last entry, leaves
//   busy low; a tick whose frame is not due ends in ST_CHECK without a result.
//   tick: the first release goes from accept straight to ST_EMIT, a later
//   tick passes ST_CHECK (advance check) first; then one result per cycle,
//   up to 64 per tick. busy drops in the cycle after the last result.
// Reset:
//   asynchronous, active low; empties the table, the play position returns
//   to the first entry and no frame counts as released.
`default_nettype none

module timed_keyframe_release import tkr_pkg::*; #(
  parameter int unsigned MaxFrames = TKR_MAX_FRAMES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  operation_i,
  input  wire logic [TKR_DATA_W-1:0] frame_time_i,
  input  wire logic [TKR_DATA_W-1:0] frame_payload_i,
  input  wire logic [TKR_DATA_W-1:0] elapsed_ms_i,
  output logic                       valid_o,
  output logic      [TKR_DATA_W-1:0] target_time_o,
  output logic      [TKR_DATA_W-1:0] target_payload_o,
  output logic                       last_of_run_o,
  output logic                       finished_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  tkr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // table and compares
  tkr_datapath #(
    .MaxFrames (MaxFrames)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .frame_time_i     (frame_time_i),
    .frame_payload_i  (frame_payload_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .target_time_o    (target_time_o),
    .target_payload_o (target_payload_o),
    .last_of_run_o    (last_of_run_o),
    .finished_o       (finished_o),
    .valid_o          (valid_o)
  );

endmodule

`default_nettype wire

// ===== rtl/tkr_ctrl.sv =====
// controller state machine sequencing inserts and frame releases
`default_nettype none

module tkr_ctrl import tkr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire logic operation_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy
);

  state_e state_q, state_d;
  logic   is_tick;

  assign is_tick = (operation_i == 1'(OP_TICK));
  assign busy    = (state_q != ST_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (!is_tick) begin
            if (!sts_i.full) state_d = ST_INS_RD;
          end else if (!sts_i.empty && !sts_i.at_last) begin
            state_d = sts_i.first ? ST_CHECK : ST_EMIT;
          end
        end
      end
      ST_INS_RD: begin
        state_d = sts_i.k_zero ? ST_IDLE : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_d = sts_i.ins_gt ? ST_INS_RD : ST_IDLE;
      end
      ST_CHECK: begin
        state_d = sts_i.due ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        state_d = sts_i.more ? ST_EMIT : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel = RD_POS;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (is_tick && !sts_i.empty && !sts_i.at_last && !sts_i.first) begin
            cmd_o.set_first = 1'b1;
          end
        end
      end
      ST_INS_RD: begin
        if (sts_i.k_zero) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_new   = 1'b1;
          cmd_o.ins_done = 1'b1;
        end else begin
          cmd_o.rd_sel = RD_INS;
        end
      end
      ST_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.ins_gt) begin
          cmd_o.k_dec = 1'b1;
        end else begin
          cmd_o.wr_new   = 1'b1;
          cmd_o.ins_done = 1'b1;
        end
      end
      ST_CHECK: begin
        if (sts_i.due) begin
          cmd_o.pos_inc = 1'b1;
          cmd_o.rd_sel  = RD_NEXT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.more) begin
          cmd_o.pos_inc = 1'b1;
          cmd_o.n_inc   = 1'b1;
          cmd_o.rd_sel  = RD_NEXT;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tkr_datapath.sv =====
// datapath: keyframe table memory, play position, counters and compares
`default_nettype none

module tkr_datapath import tkr_pkg::*; #(
  parameter int unsigned MaxFrames = TKR_MAX_FRAMES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  input  wire logic [TKR_DATA_W-1:0] frame_time_i,
  input  wire logic [TKR_DATA_W-1:0] frame_payload_i,
  input  wire logic [TKR_DATA_W-1:0] elapsed_ms_i,
  output logic      [TKR_DATA_W-1:0] target_time_o,
  output logic      [TKR_DATA_W-1:0] target_payload_o,
  output logic                       last_of_run_o,
  output logic                       finished_o,
  output logic                       valid_o
);

  localparam int unsigned IdxW = $clog2(MaxFrames);
  localparam int unsigned CntW = $clog2(MaxFrames + 1);

  // table storage
  logic [TKR_DATA_W-1:0] time_mem [MaxFrames];
  logic [TKR_DATA_W-1:0] pay_mem  [MaxFrames];
  logic [TKR_DATA_W-1:0] rd_time_q, rd_pay_q;

  // latched item fields
  logic [TKR_DATA_W-1:0] item_time_q, item_pay_q, elapsed_q;

  // control state
  logic [CntW-1:0]      count_q, k_q;
  logic [IdxW-1:0]      pos_q;
  logic                 first_q;
  logic [TKR_RES_W-1:0] n_q;

  logic [IdxW-1:0]       rd_addr, wr_addr;
  logic [TKR_DATA_W-1:0] wr_time, wr_pay;
  logic [CntW-1:0]       pos_plus1;
  logic                  at_last, due, n_lim;

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      RD_NEXT: rd_addr = pos_q + IdxW'(1);
      RD_INS:  rd_addr = IdxW'(k_q - CntW'(1));
      default: rd_addr = pos_q;
    endcase
  end

  assign wr_addr = IdxW'(k_q);
  assign wr_time = cmd_i.wr_new ? item_time_q : rd_time_q;
  assign wr_pay  = cmd_i.wr_new ? item_pay_q  : rd_pay_q;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      time_mem[wr_addr] <= wr_time;
      pay_mem[wr_addr]  <= wr_pay;
    end
    rd_time_q <= time_mem[rd_addr];
    rd_pay_q  <= pay_mem[rd_addr];
  end

  // item latch on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_time_q <= frame_time_i;
      item_pay_q  <= frame_payload_i;
      elapsed_q   <= elapsed_ms_i;
    end
  end

  // table fill, play position, insert index and result count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      k_q     <= '0;
      pos_q   <= '0;
      first_q <= 1'b0;
      n_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        k_q <= count_q;
        n_q <= '0;
      end else begin
        if (cmd_i.k_dec) k_q <= k_q - CntW'(1);
        if (cmd_i.n_inc) n_q <= n_q + TKR_RES_W'(1);
      end
      if (cmd_i.ins_done) begin
        count_q <= count_q + CntW'(1);
        pos_q   <= '0;
      end else if (cmd_i.pos_inc) begin
        pos_q <= pos_q + IdxW'(1);
      end
      if (cmd_i.set_first) first_q <= 1'b1;
    end
  end

  // status compares
  assign pos_plus1 = CntW'(pos_q) + CntW'(1);
  assign at_last   = (pos_plus1 >= count_q);
  assign due       = (rd_time_q < elapsed_q);
  assign n_lim     = (n_q == TKR_RES_W'(TKR_MAX_RESULTS - 1));

  always_comb begin
    sts_o.empty   = (count_q == '0);
    sts_o.full    = (count_q == CntW'(MaxFrames));
    sts_o.at_last = at_last;
    sts_o.first   = first_q;
    sts_o.k_zero  = (k_q == '0);
    sts_o.ins_gt  = (rd_time_q > item_time_q);
    sts_o.due     = due;
    sts_o.more    = !at_last && due && !n_lim;
  end

  // result ports, shown during the emit cycle
  assign valid_o          = cmd_i.emit;
  assign target_time_o    = rd_time_q;
  assign target_payload_o = rd_pay_q;
  assign finished_o       = at_last;
  assign last_of_run_o    = !sts_o.more;

endmodule

`default_nettype wire

// ===== rtl/tkr_checker.sv =====
// port-level checker for the timed keyframe release block, with its bind
`default_nettype none

module tkr_checker import tkr_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic operation_i,
  input wire logic valid_o,
  input wire logic last_of_run_o,
  input wire logic finished_o
);

  // results only while an item is in progress
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result outside a busy period");

  // an add item never yields a result
  a_add_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == 1'(OP_ADD)) |=> !valid_o)
    else $error("result after add item");

  // a run continues cycle by cycle until its last frame
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_of_run_o) |=> valid_o) else $error("gap inside a release run");

  // nothing follows the last frame of a run
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_of_run_o) |=> !valid_o) else $error("result after end of run");

  // the table's last entry always closes the run
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && finished_o) |-> last_of_run_o) else $error("finished without last_of_run");

endmodule

bind timed_keyframe_release tkr_checker u_tkr_checker (.*);

`default_nettype wire
